// File: design/sm3_pkg.sv
// ----------------------------------------------------------------------------
// SM3 package
// Shared types, constants and round helper functions of the SM3 hash engine.
// ----------------------------------------------------------------------------
`default_nettype none
package sm3_pkg;

  localparam logic [31:0] T_LOW  = 32'h79cc4519;
  localparam logic [31:0] T_HIGH = 32'h7a879d8a;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  function automatic word_t iv_word(input logic [2:0] i);
    word_t w;
    unique case (i)
      3'd0: w = 32'h7380166f;
      3'd1: w = 32'h4914b2b9;
      3'd2: w = 32'h172442d7;
      3'd3: w = 32'hda8a0600;
      3'd4: w = 32'ha96f30bc;
      3'd5: w = 32'h163138aa;
      3'd6: w = 32'he38dee4d;
      default: w = 32'hb0fb0e4e;
    endcase
    return w;
  endfunction

  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic word_t perm0(input word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t perm1(input word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage
`default_nettype wire

// File: design/sm3_buf_ram.sv
// ----------------------------------------------------------------------------
// SM3 block buffer
// 16 x 32-bit word memory holding the message block, with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module sm3_buf_ram
  import sm3_pkg::*;
(
  input  wire        clk,
  input  wire        we,
  input  wire [3:0]  waddr,
  input  word_t      wdata,
  input  wire [3:0]  raddr,
  output word_t      rdata
);
  word_t mem [16];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: design/sm3_round.sv
// ----------------------------------------------------------------------------
// SM3 round unit
// Holds A..H and the 16-word expansion window; performs one round per cycle while step is high.
// ----------------------------------------------------------------------------
`default_nettype none
module sm3_round
  import sm3_pkg::*;
(
  input  wire        clk,
  input  wire        load_en,    // shift a fresh block word into the window
  input  word_t      load_word,
  input  wire        init,       // copy chain value into A..H
  input  word_t      cv [8],
  input  wire        step,
  input  wire [5:0]  j,
  output word_t      regs [8]
);
  word_t w [16];   // w[0] is W[j]
  word_t r [8];
  word_t wj, wpj, tj, a12, ss1, ss2, tt1, tt2, ff, gg, nw;

  assign regs = r;

  always_comb begin
    wj  = w[0];
    wpj = wj ^ w[4];
    tj  = (j < 6'd16) ? T_LOW : T_HIGH;
    a12 = rotl(r[0], 5'd12);
    ss1 = rotl(a12 + r[4] + rotl(tj, j[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (j < 6'd16) begin
      ff = r[0] ^ r[1] ^ r[2];
      gg = r[4] ^ r[5] ^ r[6];
    end else begin
      ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
      gg = (r[4] & r[5]) | (~r[4] & r[6]);
    end
    tt1 = ff + r[3] + ss2 + wpj;
    tt2 = gg + r[7] + ss1 + wj;
    nw  = perm1(wj ^ w[7] ^ rotl(w[13], 5'd15)) ^ rotl(w[3], 5'd7) ^ w[10];
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      for (int k = 0; k < 15; k++) w[k] <= w[k+1];
      w[15] <= load_word;
    end else if (step) begin
      for (int k = 0; k < 15; k++) w[k] <= w[k+1];
      w[15] <= nw;
    end
    if (init) begin
      r <= cv;
    end else if (step) begin
      r[3] <= r[2];
      r[2] <= rotl(r[1], 5'd9);
      r[1] <= r[0];
      r[0] <= tt1;
      r[7] <= r[6];
      r[6] <= rotl(r[5], 5'd19);
      r[5] <= r[4];
      r[4] <= perm0(tt2);
    end
  end
endmodule
`default_nettype wire

// File: design/sm3_hash_engine_unit.sv
// ----------------------------------------------------------------------------
// SM3 hash engine
// Byte-stream SM3 hash with padding and eight-word digest output.
// ----------------------------------------------------------------------------
// Usage: send message bytes on s_axis; tdata[7:0] is the byte, tuser[0] marks
// that a byte is present, tlast marks the final request of the message.
// Bytes are packed into 32-bit words and written to the block memory;
// requests are taken only in the idle state. When a block of 64 bytes is full
// the core loads 16 words from the memory, runs 64 rounds at one per cycle and
// folds into the chain value; no byte is taken while a block is processed.
// On the last request the core pads in the memory, runs one or two final
// blocks and then presents eight digest words on m_axis, word 0 first, tuser
// carrying the index and tlast set on word 7. A stall on m_axis holds the
// current word; no request is taken until the digest has been delivered.
// Reset returns the initial value, empty message.
`default_nettype none
module sm3_hash_engine_unit
  import sm3_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] msg_byte
  input  wire  [0:0]  s_axis_tuser,   // [0] byte_present
  input  wire         s_axis_tlast,   // is_last
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast    // last_word
);
  state_t state, state_next;
  word_t  cv [8];
  word_t  regs [8];
  word_t  acc;          // partial word being assembled
  logic [5:0]  pos;     // byte position in block
  logic [63:0] bitlen;
  logic [6:0]  cnt;     // load / round counter
  logic        final_run, need_second, pad_done, pad_mode;
  logic [3:0]  pad_idx;
  logic [2:0]  oidx;

  // memory port
  logic  we;
  logic [3:0] waddr, raddr;
  word_t wdata, rdata;

  logic take, byte_in, load_en, init, step;
  word_t acc_new;

  sm3_buf_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  sm3_round u_round (
    .clk(clk), .load_en(load_en), .load_word(rdata), .init(init), .cv(cv),
    .step(step), .j(cnt[5:0]), .regs(regs)
  );

  assign take    = s_axis_tvalid && s_axis_tready;
  assign byte_in = take && s_axis_tuser[0];

  always_comb begin
    unique case (pos[1:0])
      2'd0: acc_new = {s_axis_tdata, 24'd0};
      2'd1: acc_new = {acc[31:24], s_axis_tdata, 16'd0};
      2'd2: acc_new = {acc[31:16], s_axis_tdata, 8'd0};
      default: acc_new = {acc[31:8], s_axis_tdata};
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (byte_in && pos == 6'd63) state_next = ST_LOAD;
        else if (take && s_axis_tlast) state_next = ST_LOAD;
      end
      ST_LOAD:  if (pad_done && cnt == 7'd16) state_next = ST_ROUND;
      ST_ROUND: if (cnt == 7'd63) state_next = ST_FOLD;
      ST_FOLD: begin
        if (!final_run) state_next = ST_IDLE;
        else if (need_second) state_next = ST_LOAD;
        else state_next = ST_EMIT;
      end
      ST_EMIT: if (m_axis_tready && oidx == 3'd7) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and memory control
  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    m_axis_tvalid = (state == ST_EMIT);
    m_axis_tdata  = cv[oidx];
    m_axis_tuser  = oidx;
    m_axis_tlast  = (oidx == 3'd7);
    we = 1'b0; waddr = pos[5:2]; wdata = acc_new;
    raddr = cnt[3:0];
    load_en = 1'b0; init = 1'b0; step = 1'b0;
    if (state == ST_IDLE && byte_in && pos[1:0] == 2'd3) we = 1'b1;
    if (state == ST_LOAD) begin
      if (!pad_done) begin
        // write padding words
        we = 1'b1;
        waddr = pad_idx;
        if (pad_mode && pad_idx == 4'd14) wdata = bitlen[63:32];
        else if (pad_mode && pad_idx == 4'd15) wdata = bitlen[31:0];
        else if (pad_idx == pos[5:2] && !pad_mode)
          wdata = acc;
        else if (pad_idx == pos[5:2] && pad_mode && !need_second)
          wdata = acc;
        else wdata = 32'd0;
        raddr = 4'd0;
      end else begin
        load_en = (cnt != 7'd0);
        init = (cnt == 7'd16);
      end
    end
    if (state == ST_ROUND) step = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      for (int k = 0; k < 8; k++) cv[k] <= iv_word(3'(k));
      pos <= 6'd0; bitlen <= 64'd0; cnt <= 7'd0; oidx <= 3'd0;
      final_run <= 1'b0; need_second <= 1'b0; pad_done <= 1'b1;
      pad_mode <= 1'b0; pad_idx <= 4'd0; acc <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          cnt <= 7'd0;
          if (take) begin
            logic [5:0] p;
            logic [63:0] bl;
            word_t a;
            p = pos; bl = bitlen; a = acc;
            if (s_axis_tuser[0]) begin
              a = acc_new;
              p = pos + 6'd1;
              bl = bitlen + 64'd8;
            end
            if (s_axis_tlast) begin
              final_run <= 1'b1;
              // place the pad byte into the partial word
              unique case (p[1:0])
                2'd0: a = {PAD_BYTE, 24'd0};
                2'd1: a = {a[31:24], PAD_BYTE, 16'd0};
                2'd2: a = {a[31:16], PAD_BYTE, 8'd0};
                default: a = {a[31:8], PAD_BYTE};
              endcase
              if (p == 6'd0 && s_axis_tuser[0] && pos == 6'd63) begin
                // full block first, pad word 0 afterwards
                need_second <= 1'b1;
                pad_done <= 1'b1;
                pad_mode <= 1'b0;
                pad_idx <= 4'd0;
              end else begin
                need_second <= (p >= 6'd56);
                pad_mode <= (p < 6'd56);
                pad_done <= 1'b0;
                pad_idx <= p[5:2];
              end
            end else begin
              final_run <= 1'b0;
              pad_done <= 1'b1;
            end
            acc <= a; pos <= p; bitlen <= bl;
          end
        end
        ST_LOAD: begin
          if (!pad_done) begin
            if (pad_idx == 4'd15) pad_done <= 1'b1;
            pad_idx <= pad_idx + 4'd1;
          end else begin
            cnt <= (cnt == 7'd16) ? 7'd0 : cnt + 7'd1;
          end
        end
        ST_ROUND: cnt <= (cnt == 7'd63) ? 7'd0 : cnt + 7'd1;
        ST_FOLD: begin
          for (int k = 0; k < 8; k++) cv[k] <= cv[k] ^ regs[k];
          if (final_run && need_second) begin
            // second block: pad word at pos if not yet written, length at end
            need_second <= 1'b0;
            pad_mode <= 1'b1;
            pad_done <= 1'b0;
            pad_idx <= 4'd0;
            if (pos != 6'd0) acc <= 32'd0;
            pos <= 6'd0;
          end
          oidx <= 3'd0;
        end
        ST_EMIT: begin
          if (m_axis_tready) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              for (int k = 0; k < 8; k++) cv[k] <= iv_word(3'(k));
              bitlen <= 64'd0; pos <= 6'd0; final_run <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_axis_tready)
    else $error("request taken while busy");
  a_emit_only: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> final_run)
    else $error("digest without final block");
  a_round_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && cnt == 7'd63) |=> (state == ST_FOLD))
    else $error("round loop did not end at 64");
endmodule
`default_nettype wire

// File: verif/sm3_digest_checker.sv
// ----------------------------------------------------------------------------
// SM3 digest checker
// Watches both streams of the hash engine, computes the digest of each
// message from the accepted requests and compares the eight digest words,
// with their index and last flag.
`default_nettype none
module sm3_digest_checker
  import sm3_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  input  wire         s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,
  input  wire  [0:0]  s_axis_tuser,
  input  wire         s_axis_tlast,
  input  wire         m_axis_tvalid,
  input  wire         m_axis_tready,
  input  wire  [31:0] m_axis_tdata,
  input  wire  [2:0]  m_axis_tuser,
  input  wire         m_axis_tlast,
  output int          fail_count,
  output int          words_pending,
  output int          digests_seen
);

  typedef struct packed {
    word_t      word;
    logic [2:0] index;
    logic       last;
  } digest_word_t;

  digest_word_t expected_words[$];

  word_t       chain[8];
  logic [7:0]  msg_block[64];
  logic [63:0] msg_bits;
  logic [5:0]  fill;

  function automatic word_t rol(input word_t x, input int n);
    int k;
    k = n % 32;
    if (k == 0) return x;
    return (x << k) | (x >> (32 - k));
  endfunction

  task automatic compress_block();
    word_t w[16];
    word_t r[8];
    word_t wj, wpj, tj, a12, ss1, ss2, tt1, tt2, nw, ff, gg;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 0; i < 8; i++) r[i] = chain[i];
    for (int j = 0; j < 64; j++) begin
      wj  = w[j % 16];
      wpj = wj ^ w[(j + 4) % 16];
      tj  = (j < 16) ? 32'h79cc4519 : 32'h7a879d8a;
      a12 = rol(r[0], 12);
      ss1 = rol(a12 + r[4] + rol(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = r[0] ^ r[1] ^ r[2];
        gg = r[4] ^ r[5] ^ r[6];
      end else begin
        ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
        gg = (r[4] & r[5]) | (~r[4] & r[6]);
      end
      tt1 = ff + r[3] + ss2 + wpj;
      tt2 = gg + r[7] + ss1 + wj;
      nw = wj ^ w[(j + 7) % 16] ^ rol(w[(j + 13) % 16], 15);
      nw = nw ^ rol(nw, 15) ^ rol(nw, 23) ^ rol(w[(j + 3) % 16], 7) ^ w[(j + 10) % 16];
      r[3] = r[2]; r[2] = rol(r[1], 9); r[1] = r[0]; r[0] = tt1;
      r[7] = r[6]; r[6] = rol(r[5], 19); r[5] = r[4];
      r[4] = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
      w[j % 16] = nw;
    end
    for (int i = 0; i < 8; i++) chain[i] ^= r[i];
  endtask

  task automatic restart_message();
    chain = '{32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
              32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};
    msg_bits = '0;
    fill = '0;
  endtask

  task automatic absorb_request(input logic [7:0] b, input logic present, input logic fin);
    if (present) begin
      msg_block[fill] = b;
      msg_bits += 64'd8;
      fill++;
      if (fill == 6'd0) compress_block();
    end
    if (fin) begin
      msg_block[fill] = 8'h80;
      for (int i = int'(fill) + 1; i < 64; i++) msg_block[i] = 8'h00;
      if (fill >= 6'd56) begin
        compress_block();
        for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) msg_block[56+i] = msg_bits[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++)
        expected_words.push_back('{word: chain[i], index: 3'(i), last: (i == 7)});
      restart_message();
    end
  endtask

  initial begin
    fail_count = 0;
    digests_seen = 0;
    restart_message();
  end

  assign words_pending = expected_words.size();

  always @(posedge clk) begin
    digest_word_t e;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        absorb_request(s_axis_tdata, s_axis_tuser[0], s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          $error("digest word %h with none expected", m_axis_tdata);
          fail_count++;
        end else begin
          e = expected_words.pop_front();
          if (m_axis_tdata !== e.word) begin
            $error("digest_word: expected %h, got %h", e.word, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tuser !== e.index) begin
            $error("word_index: expected %0d, got %0d", e.index, m_axis_tuser);
            fail_count++;
          end
          if (m_axis_tlast !== e.last) begin
            $error("last_word: expected %0d, got %0d", e.last, m_axis_tlast);
            fail_count++;
          end
          if (e.last) digests_seen++;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: verif/sm3_hash_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// SM3 hash engine testbench
// Streams directed and random messages into the engine in bursts, stalls the
// digest side on a pattern, and takes the verdict from the digest checker.
// ----------------------------------------------------------------------------
`default_nettype none
module sm3_hash_engine_unit_tb;
  import sm3_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  int          fail_count, words_pending, digests_seen;
  int          idle_cycles;
  int          requests_sent;
  bit          hold_off;

  sm3_hash_engine_unit dut (.*);

  sm3_digest_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Send one request; bursts of random length, random gaps between them.
  int burst_left;
  task automatic send_request(input logic [7:0] b, input logic present, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= present;
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
    requests_sent++;
  endtask

  task automatic send_message(input int len, input bit lone_end);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      send_request(8'($urandom), 1'b1, !lone_end && i == len - 1);
    end
    if (lone_end || len == 0) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  // Receiver: stall on a randomly chosen pattern, plus one long hold-off.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      case ($urandom_range(0, 3))
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(posedge clk);
    wait (idle_cycles >= IDLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int lens[$];
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    s_axis_tlast = 1'b0;
    hold_off = 1'b0;
    burst_left = 0;
    requests_sent = 0;
    idle_cycles = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty message, all-ones and all-zero bytes, "abc", requests without a byte.
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    send_request(8'h5a, 1'b0, 1'b0);
    send_request(8'ha5, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);

    // Fill the digest side while it holds off.
    hold_off = 1'b1;
    lens = '{55, 56, 63, 64, 3, 2, 1};
    foreach (lens[k]) send_message(lens[k], 1'($urandom_range(0, 1)));

    while (requests_sent < 330) begin
      if ($urandom_range(0, 9) == 0)
        send_message($urandom_range(60, 140), 1'($urandom_range(0, 1)));
      else send_message($urandom_range(0, 20), $urandom_range(0, 3) == 0);
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk);

    wait (words_pending == 0);
    repeat (200) @(posedge clk);
    $display("Sent %0d requests, checked %0d digests including empty and boundary lengths.",
             requests_sent, digests_seen);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
